@@ hdl/mwpm_pkg.sv @@
// ----------------------------------------------------------------------------
// mwpm_pkg: shared definitions for the masked window pattern matcher
// Register map, rule kind codes, default parameter values and the rule bundle
// that the top level hands to every window cell.
// ----------------------------------------------------------------------------
`default_nettype none

package mwpm_pkg;

    // Defaults for the top-level parameters.
    localparam int MAX_PATTERN_BYTES_DEF = 8;
    localparam int OFFSET_BITS_DEF       = 16;

    // Configuration port geometry: 64-bit registers at byte address 8*i.
    localparam int DATA_W     = 64;
    localparam int ADDR_W     = 6;
    localparam int REG_IDX_W  = 3;
    localparam int REG_LSB    = 3;

    // Register indexes.
    localparam logic [REG_IDX_W-1:0] REG_RULE_KIND      = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_PATTERN_VALUE  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_PATTERN_MASK   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_PATTERN_LENGTH = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_START_OFFSET   = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_END_OFFSET     = 3'd5;

    // Rule kinds.
    localparam logic [2:0] KIND_STRING   = 3'd0;
    localparam logic [2:0] KIND_BYTE     = 3'd1;
    localparam logic [2:0] KIND_BIG16    = 3'd2;
    localparam logic [2:0] KIND_LITTLE16 = 3'd3;
    localparam logic [2:0] KIND_BIG32    = 3'd4;
    localparam logic [2:0] KIND_LITTLE32 = 3'd5;
    localparam logic [2:0] KIND_HOST     = 3'd6;

    // Field widths.
    localparam int KIND_W   = 3;
    localparam int LENGTH_W = 4;
    localparam int CFG_OFFSET_W = 16;

    // Reset values.
    localparam logic [63:0] MASK_RESET   = 64'hffff_ffff_ffff_ffff;
    localparam logic [3:0]  LENGTH_RESET = 4'd1;

    // Decoded rule, identical for all cells.
    typedef struct packed {
        logic [63:0] value;      // pattern bytes, first byte lowest
        logic [63:0] mask;       // effective mask bytes, same layout
        logic [3:0]  span;       // bytes the rule covers, zero if it never matches
        logic        reversed;   // newest byte pairs with the last pattern byte
        logic        raw_value;  // compare against the value without masking it
    } rule_t;

endpackage : mwpm_pkg

`default_nettype wire

@@ hdl/mwpm_intf.sv @@
// ----------------------------------------------------------------------------
// mwpm_intf: request channels of the masked window pattern matcher
// One channel for incoming buffer bytes and one for the per-buffer result.
// ----------------------------------------------------------------------------
`default_nettype none

interface mwpm_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface : mwpm_byte_if

interface mwpm_result_if;
    logic valid;
    logic ready;
    logic matched;

    modport source (output valid, output matched, input ready);
    modport sink   (input valid, input matched, output ready);
endinterface : mwpm_result_if

`default_nettype wire

@@ hdl/mwpm_cell.sv @@
// ----------------------------------------------------------------------------
// mwpm_cell: one byte cell of the match window
// Holds one window byte, hands it to the next cell on every accepted request
// and checks the byte it is about to take against its pattern byte.
// ----------------------------------------------------------------------------
`default_nettype none

module mwpm_cell #(
    parameter int CELL_INDEX = 0
) (
    input  wire logic           clk,
    input  wire logic           shift,
    input  wire logic [7:0]     byte_in,
    input  wire mwpm_pkg::rule_t rule,
    output logic [7:0]          byte_out,
    output logic                hit
);

    logic [7:0] byte_reg;
    logic [3:0] sel;
    logic       active;
    logic [7:0] pat_byte;
    logic [7:0] mask_byte;
    logic [7:0] ref_byte;

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            byte_reg <= byte_in;
        end
    end

    assign byte_out = byte_reg;

    // Pick the pattern byte that lines up with this window position.
    always_comb
    begin
        active = 4'(CELL_INDEX) < rule.span;
        if (rule.reversed)
        begin
            sel = rule.span - 4'd1 - 4'(CELL_INDEX);
        end
        else
        begin
            sel = 4'(CELL_INDEX);
        end
        pat_byte  = rule.value[{sel[2:0], 3'b000} +: 8];
        mask_byte = rule.mask[{sel[2:0], 3'b000} +: 8];
        ref_byte  = rule.raw_value ? pat_byte : (pat_byte & mask_byte);
        hit       = !active || ((byte_in & mask_byte) == ref_byte);
    end

endmodule : mwpm_cell

`default_nettype wire

@@ hdl/masked_window_pattern_matcher.sv @@
// ----------------------------------------------------------------------------
// masked_window_pattern_matcher: masked pattern search over a byte stream
// Streams a buffer one byte per request through a row of window cells and
// reports, on the final byte, whether the masked rule began at any allowed
// offset of the buffer.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Payload                  Handshake
//  bytes     sink       data_byte, last_byte     valid / ready
//  result    source     matched                  valid / ready
//  APB       slave      64-bit registers at 8*i  psel, penable, pwrite, pready
//
// Each accepted byte is handled in the cycle it is accepted: the window cells
// compare their next bytes in parallel, so one byte per cycle is sustained.
// A result reaches the output register in the cycle after the final byte is
// accepted. Reset clears the counters, the found flag and the registers to
// their documented defaults; no clearing pass is needed.
// Bytes that do not end a buffer are taken even while a result waits; a
// final byte waits only while the output register holds an untaken result.
//
`default_nettype none

module masked_window_pattern_matcher #(
    parameter int MAX_PATTERN_BYTES = mwpm_pkg::MAX_PATTERN_BYTES_DEF,
    parameter int OFFSET_BITS       = mwpm_pkg::OFFSET_BITS_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    mwpm_byte_if.sink                        bytes,
    mwpm_result_if.source                    result,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [mwpm_pkg::ADDR_W-1:0] paddr,
    input  wire logic [mwpm_pkg::DATA_W-1:0] pwdata,
    output logic      [mwpm_pkg::DATA_W-1:0] prdata,
    output logic                             pready
);

    // String patterns are capped at eight bytes; number kinds need four.
    localparam int STR_MAX   = (MAX_PATTERN_BYTES > 8) ? 8 : MAX_PATTERN_BYTES;
    localparam int NUM_CELLS = (STR_MAX < 4) ? 4 : STR_MAX;
    localparam int CW        = OFFSET_BITS + 1;
    localparam int AW        = CW + 1;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [mwpm_pkg::KIND_W-1:0]       kind_reg;
    logic [63:0]                       value_reg;
    logic [63:0]                       mask_reg;
    logic [mwpm_pkg::LENGTH_W-1:0]     length_reg;
    logic [mwpm_pkg::CFG_OFFSET_W-1:0] start_reg;
    logic [mwpm_pkg::CFG_OFFSET_W-1:0] end_reg;

    logic                              cfg_write;
    logic [mwpm_pkg::REG_IDX_W-1:0]    cfg_idx;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_idx   = paddr[mwpm_pkg::REG_LSB +: mwpm_pkg::REG_IDX_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg   <= mwpm_pkg::KIND_STRING;
            value_reg  <= '0;
            mask_reg   <= mwpm_pkg::MASK_RESET;
            length_reg <= mwpm_pkg::LENGTH_RESET;
            start_reg  <= '0;
            end_reg    <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_idx)
                mwpm_pkg::REG_RULE_KIND:      kind_reg   <= pwdata[mwpm_pkg::KIND_W-1:0];
                mwpm_pkg::REG_PATTERN_VALUE:  value_reg  <= pwdata;
                mwpm_pkg::REG_PATTERN_MASK:   mask_reg   <= pwdata;
                mwpm_pkg::REG_PATTERN_LENGTH: length_reg <= pwdata[mwpm_pkg::LENGTH_W-1:0];
                mwpm_pkg::REG_START_OFFSET:   start_reg  <= pwdata[mwpm_pkg::CFG_OFFSET_W-1:0];
                mwpm_pkg::REG_END_OFFSET:     end_reg    <= pwdata[mwpm_pkg::CFG_OFFSET_W-1:0];
                default:                      ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            mwpm_pkg::REG_RULE_KIND:      prdata = 64'(kind_reg);
            mwpm_pkg::REG_PATTERN_VALUE:  prdata = value_reg;
            mwpm_pkg::REG_PATTERN_MASK:   prdata = mask_reg;
            mwpm_pkg::REG_PATTERN_LENGTH: prdata = 64'(length_reg);
            mwpm_pkg::REG_START_OFFSET:   prdata = 64'(start_reg);
            mwpm_pkg::REG_END_OFFSET:     prdata = 64'(end_reg);
            default:                      prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Rule decode
    // ------------------------------------------------------------------
    // String rules pair the newest byte with the last pattern byte, as do the
    // little-endian number kinds. Number kinds compare against the unmasked
    // value and treat an all-zero mask over their width as all ones. A value
    // too wide for its kind, and the unused kind code, give a zero span.
    mwpm_pkg::rule_t rule;
    logic [3:0]      str_len;

    always_comb
    begin
        if (length_reg == 4'd0)
        begin
            str_len = 4'd1;
        end
        else if (length_reg > 4'(STR_MAX))
        begin
            str_len = 4'(STR_MAX);
        end
        else
        begin
            str_len = length_reg;
        end

        rule.value     = value_reg;
        rule.mask      = mask_reg;
        rule.span      = 4'd0;
        rule.reversed  = 1'b0;
        rule.raw_value = 1'b1;

        case (kind_reg)
            mwpm_pkg::KIND_STRING:
            begin
                rule.span      = str_len;
                rule.reversed  = 1'b1;
                rule.raw_value = 1'b0;
            end
            mwpm_pkg::KIND_BYTE:
            begin
                rule.span = (value_reg[63:8] == '0) ? 4'd1 : 4'd0;
                if (mask_reg[7:0] == '0)
                begin
                    rule.mask = mwpm_pkg::MASK_RESET;
                end
            end
            mwpm_pkg::KIND_BIG16, mwpm_pkg::KIND_LITTLE16:
            begin
                rule.span     = (value_reg[63:16] == '0) ? 4'd2 : 4'd0;
                rule.reversed = (kind_reg == mwpm_pkg::KIND_LITTLE16);
                if (mask_reg[15:0] == '0)
                begin
                    rule.mask = mwpm_pkg::MASK_RESET;
                end
            end
            mwpm_pkg::KIND_BIG32, mwpm_pkg::KIND_LITTLE32, mwpm_pkg::KIND_HOST:
            begin
                rule.span     = (value_reg[63:32] == '0) ? 4'd4 : 4'd0;
                rule.reversed = (kind_reg == mwpm_pkg::KIND_LITTLE32);
                if (mask_reg[31:0] == '0)
                begin
                    rule.mask = mwpm_pkg::MASK_RESET;
                end
            end
            default:
            begin
                rule.span = 4'd0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Window: a row of byte cells, cell 0 holds the newest byte
    // ------------------------------------------------------------------
    // Stale bytes from an earlier buffer never take part in a compare, since
    // a check only fires once the whole pattern lies inside this buffer.
    logic                accept;
    logic [7:0]          chain [NUM_CELLS+1];
    logic [NUM_CELLS-1:0] cell_hit;

    assign chain[0] = bytes.data_byte;

    for (genvar j = 0; j < NUM_CELLS; j++)
    begin : g_cell
        mwpm_cell #(
            .CELL_INDEX (j)
        ) u_cell (
            .clk      (clk),
            .shift    (accept),
            .byte_in  (chain[j]),
            .rule     (rule),
            .byte_out (chain[j+1]),
            .hit      (cell_hit[j])
        );
    end

    // ------------------------------------------------------------------
    // Offset check: the match would begin at count + 1 - span
    // ------------------------------------------------------------------
    logic [CW-1:0]          count_reg;
    logic [CW-1:0]          count_next;
    logic [OFFSET_BITS-1:0] lo_trim;
    logic [OFFSET_BITS-1:0] hi_trim;
    logic [AW-1:0]          pos1;
    logic [AW-1:0]          begin_pos;
    logic                   in_range;
    logic                   hit_now;

    if (OFFSET_BITS >= mwpm_pkg::CFG_OFFSET_W)
    begin : g_trim_wide
        assign lo_trim = OFFSET_BITS'(start_reg);
        assign hi_trim = OFFSET_BITS'(end_reg);
    end
    else
    begin : g_trim_narrow
        assign lo_trim = start_reg[OFFSET_BITS-1:0];
        assign hi_trim = end_reg[OFFSET_BITS-1:0];
    end

    always_comb
    begin
        pos1      = AW'(count_reg) + AW'(1);
        begin_pos = pos1 - AW'(rule.span);
        in_range  = (rule.span != 4'd0) && (pos1 >= AW'(rule.span))
                    && (begin_pos >= AW'(lo_trim)) && (begin_pos <= AW'(hi_trim));
        hit_now   = in_range && (&cell_hit);
    end

    // ------------------------------------------------------------------
    // Per-buffer state and result register
    // ------------------------------------------------------------------
    logic found_reg;
    logic found_next;
    logic out_valid_reg;
    logic out_valid_next;
    logic matched_reg;
    logic matched_next;
    logic out_free;

    assign out_free     = !out_valid_reg || result.ready;
    assign bytes.ready  = out_free || !bytes.last_byte;
    assign accept       = bytes.valid && bytes.ready;
    assign result.valid   = out_valid_reg;
    assign result.matched = matched_reg;

    always_comb
    begin
        count_next     = count_reg;
        found_next     = found_reg;
        out_valid_next = out_valid_reg && !result.ready;
        matched_next   = matched_reg;
        if (accept)
        begin
            if (bytes.last_byte)
            begin
                out_valid_next = 1'b1;
                matched_next   = found_reg || hit_now;
                found_next     = 1'b0;
                count_next     = '0;
            end
            else
            begin
                found_next = found_reg || hit_now;
                if (count_reg != '1)
                begin
                    count_next = count_reg + CW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        matched_reg <= matched_next;
    end

endmodule : masked_window_pattern_matcher

`default_nettype wire

@@ tb/masked_window_pattern_matcher_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// masked_window_pattern_matcher_test: self-checking bench for the matcher
// A table of hand-built buffers covers the rule kinds, the mask and length
// corner cases, the offset range limits and a longer buffer with a match far
// into it. Random rule settings and buffers follow, with stalls on both
// channels. Results are compared with table flags or a behavioral predictor.
// ----------------------------------------------------------------------------

module masked_window_pattern_matcher_test;

    // Local copies of the package field widths, used in size casts.
    localparam int KIND_BITS   = mwpm_pkg::KIND_W;
    localparam int LENGTH_BITS = mwpm_pkg::LENGTH_W;
    localparam int ADDR_BITS   = mwpm_pkg::ADDR_W;

    // Kind code that the block leaves unused; such a rule never matches.
    localparam logic [mwpm_pkg::KIND_W-1:0] KIND_UNUSED = 3'd7;

    // How the expected result of a table row is obtained.
    localparam logic [1:0] WANT_NO   = 2'd0;
    localparam logic [1:0] WANT_YES  = 2'd1;
    localparam logic [1:0] WANT_PRED = 2'd2;

    localparam int          WINDOW_BYTES  = (mwpm_pkg::MAX_PATTERN_BYTES_DEF > 8) ? 8
                                            : mwpm_pkg::MAX_PATTERN_BYTES_DEF;
    localparam logic [16:0] COUNT_TOP     = '1;
    localparam int          LONG_BUFFER   = 1000;    // no idling above this length
    localparam int          RANDOM_BYTES  = 480;
    localparam int          CALM_BYTES    = 150;     // closing stretch without idling
    localparam longint      LIMIT_NS      = 64'd20_000_000;

    // One row of the directed table: an optional rule setting and a buffer.
    // The buffer is pad bytes with the eight bytes of fill laid in from
    // offset place on, first byte lowest.
    typedef struct packed {
        logic                          write_cfg;
        logic [mwpm_pkg::KIND_W-1:0]   kind;
        logic [63:0]                   value;
        logic [63:0]                   mask;
        logic [mwpm_pkg::LENGTH_W-1:0] length;
        logic [15:0]                   start_off;
        logic [15:0]                   end_off;
        logic [17:0]                   buf_len;
        logic [17:0]                   place;
        logic [63:0]                   fill;
        logic [7:0]                    pad;
        logic [1:0]                    want;
    } stim_row_t;

    localparam int NUM_ROWS = 25;

    localparam stim_row_t DIRECTED_ROWS [NUM_ROWS] = '{
        // Reset defaults: single zero byte at offset zero matches.
        '{1'b0, mwpm_pkg::KIND_STRING, 64'h0, mwpm_pkg::MASK_RESET, 4'd1, 16'd0, 16'd0,
          18'd1, 18'd0, 64'h0, 8'h00, WANT_YES},
        // Reset mask is all ones, and offset one lies past the reset end offset.
        '{1'b0, mwpm_pkg::KIND_STRING, 64'h0, mwpm_pkg::MASK_RESET, 4'd1, 16'd0, 16'd0,
          18'd2, 18'd0, 64'h0001, 8'h00, WANT_NO},
        // Full eight-byte string ending on the last byte of the buffer.
        '{1'b1, mwpm_pkg::KIND_STRING, 64'h0807060504030201, mwpm_pkg::MASK_RESET, 4'd8,
          16'd0, 16'd0, 18'd8, 18'd0, 64'h0807060504030201, 8'h00, WANT_YES},
        '{1'b1, mwpm_pkg::KIND_STRING, 64'h0807060504030201, mwpm_pkg::MASK_RESET, 4'd8,
          16'd0, 16'd0, 18'd8, 18'd0, 64'h0807060504030200, 8'h00, WANT_NO},
        // A zero mask byte hides the mismatching first byte.
        '{1'b1, mwpm_pkg::KIND_STRING, 64'h0807060504030201, 64'hffff_ffff_ffff_ff00, 4'd8,
          16'd0, 16'd0, 18'd8, 18'd0, 64'h0807060504030200, 8'h00, WANT_YES},
        // Length zero is taken as one byte.
        '{1'b1, mwpm_pkg::KIND_STRING, 64'h42, mwpm_pkg::MASK_RESET, 4'd0, 16'd3, 16'd3,
          18'd5, 18'd3, 64'h42, 8'h00, WANT_YES},
        // Length fifteen saturates to the window size; value all ones.
        '{1'b1, mwpm_pkg::KIND_STRING, 64'hffff_ffff_ffff_ffff, mwpm_pkg::MASK_RESET, 4'd15,
          16'd0, 16'd0, 18'd8, 18'd0, 64'hffff_ffff_ffff_ffff, 8'h00, WANT_YES},
        // A string mask of zero stays zero, so anything matches.
        '{1'b1, mwpm_pkg::KIND_STRING, 64'h0123_4567_89ab_cdef, 64'h0, 4'd4, 16'd0, 16'd10,
          18'd6, 18'd0, 64'h0, 8'h3c, WANT_YES},
        // Byte kind with an empty mask treated as all ones.
        '{1'b1, mwpm_pkg::KIND_BYTE, 64'hff, 64'h0, 4'd1, 16'd0, 16'd2,
          18'd3, 18'd2, 64'hff, 8'h00, WANT_YES},
        // Value too wide for a byte never matches.
        '{1'b1, mwpm_pkg::KIND_BYTE, 64'h100, mwpm_pkg::MASK_RESET, 4'd1, 16'd0, 16'd2,
          18'd3, 18'd0, 64'h0, 8'h00, WANT_NO},
        '{1'b1, mwpm_pkg::KIND_BIG16, 64'h1234, mwpm_pkg::MASK_RESET, 4'd1, 16'd1, 16'd1,
          18'd4, 18'd1, 64'h3412, 8'h00, WANT_YES},
        '{1'b1, mwpm_pkg::KIND_LITTLE16, 64'h1234, mwpm_pkg::MASK_RESET, 4'd1, 16'd1, 16'd1,
          18'd4, 18'd1, 64'h1234, 8'h00, WANT_YES},
        '{1'b1, mwpm_pkg::KIND_BIG32, 64'hdead_beef, mwpm_pkg::MASK_RESET, 4'd1, 16'd0, 16'd0,
          18'd4, 18'd0, 64'hefbe_adde, 8'h00, WANT_YES},
        '{1'b1, mwpm_pkg::KIND_LITTLE32, 64'hdead_beef, mwpm_pkg::MASK_RESET, 4'd1,
          16'd0, 16'd0, 18'd4, 18'd0, 64'hdead_beef, 8'h00, WANT_YES},
        // Host order behaves as big order.
        '{1'b1, mwpm_pkg::KIND_HOST, 64'hdead_beef, mwpm_pkg::MASK_RESET, 4'd1, 16'd0, 16'd0,
          18'd4, 18'd0, 64'hefbe_adde, 8'h00, WANT_YES},
        '{1'b1, mwpm_pkg::KIND_BIG32, 64'h1_0000_0000, mwpm_pkg::MASK_RESET, 4'd1,
          16'd0, 16'd8, 18'd8, 18'd0, 64'h0, 8'h00, WANT_NO},
        '{1'b1, KIND_UNUSED, 64'h0, mwpm_pkg::MASK_RESET, 4'd1, 16'd0, 16'd8,
          18'd8, 18'd0, 64'h0, 8'h00, WANT_NO},
        // Value bits outside the number mask block any match.
        '{1'b1, mwpm_pkg::KIND_BIG16, 64'h00ff, 64'h0f0f, 4'd1, 16'd0, 16'd0,
          18'd2, 18'd0, 64'hff00, 8'h00, WANT_NO},
        '{1'b1, mwpm_pkg::KIND_BIG16, 64'h0102, 64'h0f0f, 4'd1, 16'd0, 16'd0,
          18'd2, 18'd0, 64'hf2f1, 8'h00, WANT_YES},
        // Start above end: empty range.
        '{1'b1, mwpm_pkg::KIND_BYTE, 64'h0, mwpm_pkg::MASK_RESET, 4'd1, 16'd5, 16'd2,
          18'd8, 18'd0, 64'h0, 8'h00, WANT_NO},
        // Offsets past the end of a short buffer.
        '{1'b1, mwpm_pkg::KIND_BYTE, 64'h0, mwpm_pkg::MASK_RESET, 4'd1, 16'hffff, 16'hffff,
          18'd4, 18'd0, 64'h0, 8'h00, WANT_NO},
        // Pattern longer than the whole buffer.
        '{1'b1, mwpm_pkg::KIND_STRING, 64'h0, mwpm_pkg::MASK_RESET, 4'd2, 16'd0, 16'hffff,
          18'd1, 18'd0, 64'h0, 8'h00, WANT_NO},
        // Match far into a longer buffer, with the range open up to the top
        // offset.
        '{1'b1, mwpm_pkg::KIND_BYTE, 64'ha5, mwpm_pkg::MASK_RESET, 4'd1, 16'd60, 16'hffff,
          18'd80, 18'd70, 64'ha5, 8'h00, WANT_YES},
        '{1'b1, mwpm_pkg::KIND_STRING, 64'h00c3_b2a1, 64'h00f0_f0f0, 4'd3, 16'd0, 16'd9,
          18'd12, 18'd5, 64'h00c5_b7a9, 8'h5a, WANT_PRED},
        // Number mask with empty low bytes acts as all ones.
        '{1'b1, mwpm_pkg::KIND_LITTLE32, 64'hbeef, 64'hffff_ffff_0000_0000, 4'd1,
          16'd0, 16'd6, 18'd10, 18'd6, 64'hbeef, 8'h11, WANT_PRED}
    };

    logic                          clk;
    logic                          rst_n;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [mwpm_pkg::ADDR_W-1:0]   paddr;
    logic [mwpm_pkg::DATA_W-1:0]   pwdata;
    logic [mwpm_pkg::DATA_W-1:0]   prdata;
    logic                          pready;

    mwpm_byte_if   byte_ch();
    mwpm_result_if result_ch();

    masked_window_pattern_matcher u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .bytes   (byte_ch),
        .result  (result_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Local copy of the rule registers, updated after all six writes of a setting.
    logic [mwpm_pkg::KIND_W-1:0]       cfg_kind;
    logic [63:0]                       cfg_value;
    logic [63:0]                       cfg_mask;
    logic [mwpm_pkg::LENGTH_W-1:0]     cfg_length;
    logic [mwpm_pkg::CFG_OFFSET_W-1:0] cfg_start;
    logic [mwpm_pkg::CFG_OFFSET_W-1:0] cfg_end;

    // Predictor state for the buffer in flight.
    logic [63:0] history;
    logic [16:0] seen_count;
    bit          hit_seen;

    // Expected match flags, oldest first, one per buffer.
    bit match_expect_q [$];

    bit         idle_on;
    logic [1:0] typed_want;
    int         stall_left;
    int         errors;
    int         bytes_sent;
    int         buffers_sent;
    int         results_seen;
    int         match_count;
    int         settings_count;
    int         random_bytes;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop in case the block hangs on either channel.
    initial
    begin
        #(LIMIT_NS);
        $display("CHECK FAILED");
        $finish;
    end

    function automatic logic [63:0] low_bytes_mask(input int n);
        return (n >= 8) ? '1 : ((64'd1 << (8 * n)) - 64'd1);
    endfunction

    // Number of bytes the current rule spans, or zero when it can never match.
    function automatic int rule_span();
        int len;
        len = (cfg_length == 0) ? 1
            : ((cfg_length > WINDOW_BYTES) ? WINDOW_BYTES : int'(cfg_length));
        case (cfg_kind)
            mwpm_pkg::KIND_STRING:
                return len;
            mwpm_pkg::KIND_BYTE:
                return (cfg_value <= 64'hff) ? 1 : 0;
            mwpm_pkg::KIND_BIG16, mwpm_pkg::KIND_LITTLE16:
                return (cfg_value <= 64'hffff) ? 2 : 0;
            mwpm_pkg::KIND_BIG32, mwpm_pkg::KIND_LITTLE32, mwpm_pkg::KIND_HOST:
                return (cfg_value <= 64'hffff_ffff) ? 4 : 0;
            default:
                return 0;
        endcase
    endfunction

    // Does the rule match the newest n bytes of the history?
    function automatic bit window_hit(input int n);
        logic [63:0] lm;
        logic [63:0] w;
        logic [63:0] m;
        logic [63:0] swapped;
        logic [7:0]  wb;
        logic [7:0]  mb;
        bit          ok;
        ok = 1'b1;
        if (cfg_kind == mwpm_pkg::KIND_STRING)
        begin
            // The oldest byte of the window pairs with the first pattern byte.
            for (int k = 0; k < n; k++)
            begin
                wb = history[8 * (n - 1 - k) +: 8];
                mb = cfg_mask[8 * k +: 8];
                if ((wb & mb) != (cfg_value[8 * k +: 8] & mb))
                    ok = 1'b0;
            end
            return ok;
        end
        lm = low_bytes_mask(n);
        w  = history & lm;
        m  = cfg_mask & lm;
        if (m == 64'd0)
            m = lm;
        if (cfg_kind == mwpm_pkg::KIND_LITTLE16 || cfg_kind == mwpm_pkg::KIND_LITTLE32)
        begin
            swapped = 64'd0;
            for (int k = 0; k < n; k++)
                swapped = (swapped << 8) | 64'(w[8 * k +: 8]);
            w = swapped;
        end
        return (w & m) == cfg_value;
    endfunction

    // Advance the predictor by one accepted byte; the final byte of a buffer
    // queues the expected match flag and clears the per-buffer state.
    function automatic void predict_byte(input logic [7:0] d, input logic is_last);
        int     n;
        longint pos;
        longint p;
        pos = longint'(seen_count);
        n   = rule_span();
        history = {history[55:0], d};
        if (seen_count != COUNT_TOP)
            seen_count = seen_count + 17'd1;
        if (n != 0 && pos + 1 >= n)
        begin
            p = pos + 1 - n;
            if (p >= longint'(cfg_start) && p <= longint'(cfg_end) && window_hit(n))
                hit_seen = 1'b1;
        end
        if (is_last)
        begin
            if (typed_want == WANT_PRED)
                match_expect_q.push_back(hit_seen);
            else
                match_expect_q.push_back(typed_want == WANT_YES);
            history    = 64'd0;
            seen_count = 17'd0;
            hit_seen   = 1'b0;
        end
    endfunction

    // Every accepted byte request feeds the predictor.
    always @(posedge clk)
    begin
        if (rst_n && byte_ch.valid && byte_ch.ready)
            predict_byte(byte_ch.data_byte, byte_ch.last_byte);
    end

    // Result side back-pressure: random stall bursts while idling is enabled,
    // otherwise always ready.
    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            result_ch.ready <= 1'b0;
            stall_left = stall_left - 1;
        end
        else if (idle_on && $urandom_range(0, 3) == 0)
        begin
            result_ch.ready <= 1'b0;
            stall_left = $urandom_range(0, 2);
        end
        else
            result_ch.ready <= 1'b1;
    end

    // Compare each accepted result request with the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            results_seen = results_seen + 1;
            if (result_ch.matched === 1'b1)
                match_count = match_count + 1;
            if (match_expect_q.size() == 0)
            begin
                $error("matched: expected no result, actual %0b", result_ch.matched);
                errors = errors + 1;
            end
            else if (match_expect_q[0] !== result_ch.matched)
            begin
                $error("matched: expected %0b, actual %0b",
                       match_expect_q[0], result_ch.matched);
                errors = errors + 1;
                void'(match_expect_q.pop_front());
            end
            else
                void'(match_expect_q.pop_front());
        end
    end

    // One APB write: setup phase, then the access phase in which it lands.
    task automatic write_reg(input logic [mwpm_pkg::REG_IDX_W-1:0] idx,
                             input logic [63:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_BITS'(idx) << mwpm_pkg::REG_LSB;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
    endtask

    // Write all six rule registers and mirror them in the local copy.
    task automatic program_rule(input logic [mwpm_pkg::KIND_W-1:0] kind,
                                input logic [63:0] value,
                                input logic [63:0] mask,
                                input logic [mwpm_pkg::LENGTH_W-1:0] len,
                                input logic [15:0] lo, input logic [15:0] hi);
        write_reg(mwpm_pkg::REG_RULE_KIND, 64'(kind));
        write_reg(mwpm_pkg::REG_PATTERN_VALUE, value);
        write_reg(mwpm_pkg::REG_PATTERN_MASK, mask);
        write_reg(mwpm_pkg::REG_PATTERN_LENGTH, 64'(len));
        write_reg(mwpm_pkg::REG_START_OFFSET, 64'(lo));
        write_reg(mwpm_pkg::REG_END_OFFSET, 64'(hi));
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cfg_kind   = kind;
        cfg_value  = value;
        cfg_mask   = mask;
        cfg_length = len;
        cfg_start  = lo;
        cfg_end    = hi;
        settings_count = settings_count + 1;
    endtask

    // Offer one byte request, with an optional idle burst ahead of it, and
    // return at the edge where it is accepted.
    task automatic send_byte(input logic [7:0] d, input logic is_last);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            byte_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        byte_ch.valid     <= 1'b1;
        byte_ch.data_byte <= d;
        byte_ch.last_byte <= is_last;
        do
            @(posedge clk);
        while (!byte_ch.ready);
        bytes_sent = bytes_sent + 1;
        if (is_last)
            buffers_sent = buffers_sent + 1;
    endtask

    // Drop valid and wait until every buffer has produced its result. The
    // result register is loaded in the cycle after the final byte is accepted,
    // and the trailing wait leaves the block idle for a register write.
    task automatic wait_idle();
        byte_ch.valid <= 1'b0;
        while (results_seen < buffers_sent)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic run_row(input stim_row_t row);
        logic [7:0] b;
        int         pos;
        wait_idle();
        if (row.write_cfg)
            program_rule(row.kind, row.value, row.mask, row.length, row.start_off, row.end_off);
        typed_want = row.want;
        // A very long buffer would run flat out to keep the run short.
        idle_on = (row.buf_len <= LONG_BUFFER);
        for (int i = 0; i < int'(row.buf_len); i++)
        begin
            pos = i - int'(row.place);
            b   = (pos >= 0 && pos < 8) ? row.fill[8 * pos +: 8] : row.pad;
            send_byte(b, i == int'(row.buf_len) - 1);
        end
    endtask

    // One random rule setting followed by a few buffers. Most buffers carry
    // the pattern at an allowed offset so that matches are common; some have
    // it damaged by a single flipped bit and some are plain noise.
    task automatic random_phase();
        logic [mwpm_pkg::KIND_W-1:0]   kind;
        logic [mwpm_pkg::LENGTH_W-1:0] len;
        logic [63:0]                   value;
        logic [63:0]                   mask;
        logic [63:0]                   lm;
        logic [63:0]                   eff;
        logic [15:0]                   lo;
        logic [15:0]                   hi;
        logic [7:0]                    vb;
        logic [7:0]                    mb;
        logic [7:0]                    frame [0:63];
        int                            n;
        int                            nbuf;
        int                            blen;
        int                            p;
        int                            top;
        bit                            number_kind;
        bit                            too_wide;

        wait_idle();
        typed_want = WANT_PRED;

        kind = ($urandom_range(0, 11) == 0) ? KIND_UNUSED
             : KIND_BITS'($urandom_range(mwpm_pkg::KIND_STRING, mwpm_pkg::KIND_HOST));
        len  = ($urandom_range(0, 7) == 0) ? LENGTH_BITS'($urandom_range(0, 15))
             : LENGTH_BITS'($urandom_range(1, WINDOW_BYTES));
        case (kind)
            mwpm_pkg::KIND_STRING:
                n = (len == 0) ? 1 : ((len > WINDOW_BYTES) ? WINDOW_BYTES : int'(len));
            mwpm_pkg::KIND_BYTE:
                n = 1;
            mwpm_pkg::KIND_BIG16, mwpm_pkg::KIND_LITTLE16:
                n = 2;
            default:
                n = 4;
        endcase
        number_kind = (kind != mwpm_pkg::KIND_STRING && kind != KIND_UNUSED);
        lm = low_bytes_mask(n);

        case ($urandom_range(0, 7))
            0, 1:    mask = '1;
            2:       mask = 64'd0;
            3:       mask = {$urandom, 32'd0};
            default:
                for (int k = 0; k < 8; k++)
                    mask[8 * k +: 8] = ($urandom_range(0, 1) != 0) ? 8'hff : 8'($urandom);
        endcase

        value    = {$urandom, $urandom};
        too_wide = number_kind && ($urandom_range(0, 7) == 0);
        if ($urandom_range(0, 15) == 0)
            value = '1;
        else if (too_wide)
            value = value | (64'd1 << (8 * n));
        else if (number_kind)
        begin
            value = value & lm;
            // Keep the value inside the effective mask most of the time.
            eff = mask & lm;
            if (eff == 64'd0)
                eff = lm;
            if ($urandom_range(0, 3) != 0)
                value = value & eff;
        end

        lo = 16'($urandom_range(0, 10));
        hi = lo + 16'($urandom_range(0, 12));
        case ($urandom_range(0, 15))
            0:
            begin
                lo = 16'($urandom_range(1, 10));
                hi = lo - 16'd1;
            end
            1:
            begin
                lo = 16'd0;
                hi = 16'hffff;
            end
            2:
            begin
                lo = 16'hffff;
                hi = 16'hffff;
            end
            default: ;
        endcase

        program_rule(kind, value, mask, len, lo, hi);

        nbuf = $urandom_range(2, 6);
        for (int j = 0; j < nbuf; j++)
        begin
            blen = $urandom_range(1, 16);
            for (int i = 0; i < 64; i++)
                frame[i] = 8'($urandom);
            if ($urandom_range(0, 2) != 0 && lo <= hi && lo <= 16'd20)
            begin
                top  = (int'(hi) < int'(lo) + 8) ? int'(hi) : int'(lo) + 8;
                p    = $urandom_range(int'(lo), top);
                if (blen < p + n)
                    blen = p + n + $urandom_range(0, 3);
                for (int k = 0; k < n; k++)
                begin
                    // String and little order lay the value out first byte
                    // first; big order puts its top byte first.
                    if (kind == mwpm_pkg::KIND_STRING || kind == KIND_UNUSED
                        || kind == mwpm_pkg::KIND_LITTLE16
                        || kind == mwpm_pkg::KIND_LITTLE32)
                        vb = value[8 * k +: 8];
                    else
                        vb = value[8 * (n - 1 - k) +: 8];
                    if (kind == mwpm_pkg::KIND_STRING)
                    begin
                        mb = mask[8 * k +: 8];
                        vb = (vb & mb) | (frame[p + k] & ~mb);
                    end
                    frame[p + k] = vb;
                end
                if ($urandom_range(0, 7) == 0)
                    frame[p + $urandom_range(0, n - 1)] ^= 8'(1 << $urandom_range(0, 7));
            end
            for (int i = 0; i < blen; i++)
                send_byte(frame[i], i == blen - 1);
            random_bytes = random_bytes + blen;
        end
        // The closing stretch of the run has no idling on either side.
        if (random_bytes >= RANDOM_BYTES - CALM_BYTES)
            idle_on = 1'b0;
    endtask

    initial
    begin
        // All block inputs but the result ready are known from time zero;
        // that one is driven from the first clock edge on, inside reset.
        // Reset is held low from time zero and released once.
        rst_n             <= 1'b0;
        psel              <= 1'b0;
        penable           <= 1'b0;
        pwrite            <= 1'b0;
        paddr             <= '0;
        pwdata            <= '0;
        byte_ch.valid     <= 1'b0;
        byte_ch.data_byte <= 8'h00;
        byte_ch.last_byte <= 1'b0;

        cfg_kind       = mwpm_pkg::KIND_STRING;
        cfg_value      = 64'd0;
        cfg_mask       = mwpm_pkg::MASK_RESET;
        cfg_length     = mwpm_pkg::LENGTH_RESET;
        cfg_start      = '0;
        cfg_end        = '0;
        history        = 64'd0;
        seen_count     = 17'd0;
        hit_seen       = 1'b0;
        idle_on        = 1'b1;
        typed_want     = WANT_PRED;
        stall_left     = 0;
        errors         = 0;
        bytes_sent     = 0;
        buffers_sent   = 0;
        results_seen   = 0;
        match_count    = 0;
        settings_count = 0;
        random_bytes   = 0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Directed table first; the opening rows rely on the reset settings.
        for (int r = 0; r < NUM_ROWS; r++)
            run_row(DIRECTED_ROWS[r]);

        idle_on = 1'b1;
        while (random_bytes < RANDOM_BYTES)
            random_phase();

        // Drain: every buffer must have reported, then a short settle.
        wait_idle();
        repeat (4) @(posedge clk);
        if (match_expect_q.size() != 0)
        begin
            $error("matched: %0d expected results never arrived", match_expect_q.size());
            errors = errors + 1;
        end

        $display("Streamed %0d bytes in %0d buffers under %0d rule settings.",
                 bytes_sent, buffers_sent, settings_count);
        $display("%0d buffers reported a match; %0d mismatches found.", match_count, errors);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule : masked_window_pattern_matcher_test
